// ===== hdl/mfb_pkg.sv =====
// Shared types and constants for the message frame builder.
`timescale 1ns / 1ps

package mfb_pkg;

  localparam int unsigned MaxPayload = 1014;

  localparam logic [7:0]  ByteSync    = 8'hAA;
  localparam logic [7:0]  ByteHeader  = 8'hBB;
  localparam logic [7:0]  ByteTrailer = 8'hCC;
  localparam logic [15:0] LenOverhead = 16'd10;

  localparam logic CfgDeviceAddress = 1'b0;
  localparam logic CfgAddressMode   = 1'b1;

  // One classified item as it travels from the front end to the serialiser.
  typedef struct packed {
    logic        first;
    logic        emit_data;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  seq;
    logic [15:0] len;
  } mfb_cmd_t;

  // Address bytes for the header, with a flag while a conversion is running.
  typedef struct packed {
    logic       busy;
    logic [7:0] hi;
    logic [7:0] lo;
  } mfb_addr_t;

endpackage

// ===== hdl/message_frame_builder.sv =====
// Top level of the message frame builder: front end, command queue, serialiser, address unit.
// The first byte caused by an accepted item passes the command queue and the output register.
// Unless stalled or the address unit is busy, the serialiser sends one byte per cycle; a pure
// payload beat is one byte, first beats add seven header bytes, last beats three trailer bytes.
// The queue holds the beat being expanded and up to QUEUE_DEPTH - 1 later ones; then input stalls.
// Reset clears all control state and both configuration registers; after each
// configuration write the address converter is busy for a conversion and no new bytes are emitted.
`timescale 1ns / 1ps

module message_frame_builder
  import mfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic [9:0]  payload_length_i,
  input  logic        use_sequence_i,
  input  logic [7:0]  sequence_number_i,
  output logic        frame_valid_o,
  input  logic        frame_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_end_o
);

  logic      push;
  logic      pop;
  logic      q_full;
  logic      head_valid;
  mfb_cmd_t  push_cmd;
  mfb_cmd_t  head_cmd;
  mfb_addr_t addr;

  mfb_addr_unit u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .addr_o      (addr)
  );

  mfb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .payload_byte_i    (payload_byte_i),
    .first_item_i      (first_item_i),
    .last_item_i       (last_item_i),
    .payload_length_i  (payload_length_i),
    .use_sequence_i    (use_sequence_i),
    .sequence_number_i (sequence_number_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  mfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  mfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .addr_i        (addr),
    .frame_valid_o (frame_valid_o),
    .frame_stall_i (frame_stall_i),
    .frame_byte_o  (frame_byte_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// ===== hdl/mfb_addr_unit.sv =====
// Configuration registers and the iterative binary to packed decimal address converter.
`timescale 1ns / 1ps

module mfb_addr_unit
  import mfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output mfb_addr_t   addr_o
);

  logic [15:0] dev_addr_q;
  logic        dec_mode_q;
  logic        busy_q;
  logic [2:0]  step_q;
  logic [13:0] val_q;
  logic [15:0] bcd_q;

  function automatic logic [13:0] mod_10000(input logic [15:0] a);
    logic [13:0] r;
    r = a[13:0];
    for (int k = 1; k <= 6; k++) begin
      if (17'(a) >= 17'(k * 10000)) begin
        r = 14'(17'(a) - 17'(k * 10000));
      end
    end
    return r;
  endfunction

  function automatic logic [17:0] digit_step(input logic [13:0] v, input logic [13:0] place);
    logic [3:0]  d;
    logic [13:0] r;
    d = 4'd0;
    r = v;
    for (int k = 1; k <= 9; k++) begin
      if (18'(v) >= 18'(k) * 18'(place)) begin
        d = 4'(k);
        r = 14'(18'(v) - 18'(k) * 18'(place));
      end
    end
    return {d, r};
  endfunction

  logic [13:0] place;
  logic [17:0] step_res;

  always_comb begin
    case (step_q)
      3'd1:    place = 14'd1000;
      3'd2:    place = 14'd100;
      3'd3:    place = 14'd10;
      default: place = 14'd1;
    endcase
    step_res = digit_step(val_q, place);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 16'd0;
      dec_mode_q <= 1'b0;
      busy_q     <= 1'b0;
      step_q     <= 3'd0;
      val_q      <= 14'd0;
      bcd_q      <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDeviceAddress: dev_addr_q <= cfg_wdata_i;
        CfgAddressMode:   dec_mode_q <= cfg_wdata_i[0];
        default:          dev_addr_q <= dev_addr_q;
      endcase
      busy_q <= 1'b1;
      step_q <= 3'd0;
    end else if (busy_q) begin
      if (step_q == 3'd0) begin
        val_q <= mod_10000(dev_addr_q);
      end else begin
        val_q <= step_res[13:0];
        bcd_q <= {bcd_q[11:0], step_res[17:14]};
      end
      if (step_q == 3'd4) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + 3'd1;
    end
  end

  assign addr_o.busy = busy_q;
  assign addr_o.hi   = dec_mode_q ? bcd_q[15:8] : dev_addr_q[15:8];
  assign addr_o.lo   = dec_mode_q ? bcd_q[7:0]  : dev_addr_q[7:0];

  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= 3'd4)
    else $error("Address conversion ran past its last digit.");

endmodule

// ===== hdl/mfb_front.sv =====
// Front end: accepts item beats, tracks the open frame and classifies items for the queue.
`timescale 1ns / 1ps

module mfb_front
  import mfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] payload_byte_i,
  input  logic       first_item_i,
  input  logic       last_item_i,
  input  logic [9:0] payload_length_i,
  input  logic       use_sequence_i,
  input  logic [7:0] sequence_number_i,
  input  logic       q_full_i,
  output logic       push_o,
  output mfb_cmd_t   cmd_o
);

  logic in_frame_q;
  logic in_frame_d;
  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && (first_item_i || in_frame_q);

  always_comb begin
    cmd_o.first     = first_item_i;
    cmd_o.emit_data = !(first_item_i && (payload_length_i == 10'd0));
    cmd_o.last      = last_item_i;
    cmd_o.data      = payload_byte_i;
    cmd_o.seq       = use_sequence_i ? sequence_number_i : 8'd0;
    if ({6'd0, payload_length_i} > 16'(MaxPayload)) begin
      cmd_o.len = 16'(MaxPayload) + LenOverhead;
    end else begin
      cmd_o.len = {6'd0, payload_length_i} + LenOverhead;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    if (accept) begin
      if (first_item_i) begin
        in_frame_d = !last_item_i;
      end else if (last_item_i) begin
        in_frame_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// ===== hdl/mfb_queue.sv =====
// Short command queue between the front end and the serialiser.
`timescale 1ns / 1ps

module mfb_queue
  import mfb_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mfb_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output mfb_cmd_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mfb_cmd_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Command queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("Command queue read while empty.");

endmodule

// ===== hdl/mfb_back.sv =====
// Serialiser: expands queued commands into header, payload and trailer bytes with the checksum.
`timescale 1ns / 1ps

module mfb_back
  import mfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  mfb_cmd_t   head_i,
  output logic       pop_o,
  input  mfb_addr_t  addr_i,
  output logic       frame_valid_o,
  input  logic       frame_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);

  typedef enum logic [3:0] {
    PhHdr0, PhHdr1, PhHdr2, PhHdr3, PhHdr4, PhHdr5, PhHdr6,
    PhData, PhTrl0, PhTrl1, PhTrl2
  } phase_e;

  phase_e     phase_q;
  phase_e     phase_d;
  phase_e     cur_ph;
  logic       started_q;
  logic       started_d;
  logic       done;
  logic [7:0] xor_q;
  logic [7:0] xor_d;
  logic [7:0] byte_val;
  logic       out_adv;
  logic       emit;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;

  assign out_adv = !out_valid_q || !frame_stall_i;
  assign emit    = head_valid_i && !addr_i.busy && out_adv;

  always_comb begin
    if (started_q) begin
      cur_ph = phase_q;
    end else if (head_i.first) begin
      cur_ph = PhHdr0;
    end else if (head_i.emit_data) begin
      cur_ph = PhData;
    end else begin
      cur_ph = PhTrl0;
    end
  end

  always_comb begin
    done    = 1'b0;
    phase_d = cur_ph;
    case (cur_ph)
      PhHdr0: begin byte_val = ByteSync;          phase_d = PhHdr1; end
      PhHdr1: begin byte_val = ByteHeader;        phase_d = PhHdr2; end
      PhHdr2: begin byte_val = head_i.seq;        phase_d = PhHdr3; end
      PhHdr3: begin byte_val = addr_i.hi;         phase_d = PhHdr4; end
      PhHdr4: begin byte_val = addr_i.lo;         phase_d = PhHdr5; end
      PhHdr5: begin byte_val = head_i.len[15:8];  phase_d = PhHdr6; end
      PhHdr6: begin
        byte_val = head_i.len[7:0];
        if (head_i.emit_data) begin
          phase_d = PhData;
        end else if (head_i.last) begin
          phase_d = PhTrl0;
        end else begin
          done = 1'b1;
        end
      end
      PhData: begin
        byte_val = head_i.data;
        if (head_i.last) begin
          phase_d = PhTrl0;
        end else begin
          done = 1'b1;
        end
      end
      PhTrl0: begin byte_val = ByteSync;    phase_d = PhTrl1; end
      PhTrl1: begin byte_val = ByteTrailer; phase_d = PhTrl2; end
      PhTrl2: begin byte_val = xor_q;       done = 1'b1;      end
      default: begin byte_val = 8'd0;       done = 1'b1;      end
    endcase
  end

  always_comb begin
    xor_d     = xor_q;
    started_d = started_q;
    if (emit) begin
      started_d = !done;
      if (cur_ph == PhHdr0) begin
        xor_d = ByteSync;
      end else if (cur_ph == PhTrl2) begin
        xor_d = 8'd0;
      end else begin
        xor_d = xor_q ^ byte_val;
      end
    end
  end

  assign pop_o = emit && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      started_q   <= 1'b0;
      xor_q       <= 8'd0;
      out_valid_q <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      xor_q     <= xor_d;
      if (emit) begin
        phase_q <= phase_d;
      end
      if (out_adv) begin
        out_valid_q <= emit;
        out_end_q   <= emit && (cur_ph == PhTrl2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && emit) begin
      out_byte_q <= byte_val;
    end
  end

  assign frame_valid_o = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign frame_end_o   = out_end_q;

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> head_valid_i)
    else $error("Command left the queue before all its bytes were sent.");

endmodule
